[rtl/core/x86_call_offset_untranslate_defines.svh]
// ============================================================================
// x86 CALL offset untranslate - assertion macros
// Shared concurrent assertion shorthands, clocked on clock, off in reset.
// ============================================================================
`ifndef X86_CALL_OFFSET_UNTRANSLATE_DEFINES_SVH
`define X86_CALL_OFFSET_UNTRANSLATE_DEFINES_SVH

// Same-cycle implication
`define X86COU_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define X86COU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/x86cou_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// x86cou_pkg
// Types and fixed constants of the x86 CALL offset untranslate block.
// ============================================================================
package x86cou_pkg;

   localparam logic [7:0] E8_OPCODE    = 8'hE8;  // CALL rel32 opcode byte
   localparam int         CALL_BYTES   = 5;      // opcode plus 4 operand bytes
   localparam int         HOLD_MARGIN  = 10;     // call must start this far before end
   localparam int         MIN_XLAT_LEN = 6;      // frames this short are never scanned
   localparam int         QUEUE_DEPTH  = 16;     // output queue beats, power of two

   // One output beat: byte plus frame end mark
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_beat_type;

   // Group of beats produced by one input byte
   typedef struct packed {
      logic [2:0]                        cnt;
      out_beat_type [CALL_BYTES-1:0]     beats;
   } push_type;

endpackage

[rtl/core/x86cou_beat_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// x86cou_beat_queue
// Output queue: takes up to five beats per cycle, hands out one per cycle while rsp_tready is high.
// ============================================================================
module x86cou_beat_queue import x86cou_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // frame_end
);

   localparam int DEPTH = QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   out_beat_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = mem_ff[rd_ptr_ff].data;
   assign rsp_tlast  = mem_ff[rd_ptr_ff].last;

   // Leave space for a full call group
   assign room = (count_ff <= CNT_W'(DEPTH - CALL_BYTES));

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.cnt) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the group into consecutive slots
   always_ff @(posedge clock) begin
      for (int j = 0; j < CALL_BYTES; j++) begin
         if (3'(j) < push.cnt) begin
            mem_ff[wr_ptr_ff + PTR_W'(j)] <= push.beats[j];
         end
      end
   end

endmodule

[rtl/core/x86_call_offset_untranslate.sv]
`timescale 1ns / 1ps
// A byte outside a call passes the input register and then the output queue before it
// is offered on rsp. Call bytes wait for the four operand bytes.
// Throughput: one req beat per cycle; the output queue holds QUEUE_DEPTH beats and
// req stalls only while it lacks room for a five-byte call group.
// Reset: synchronous; clears position, frame count, hold state, queue and size.
// ============================================================================
// x86_call_offset_untranslate
// Undoes x86 E8 CALL operand translation on a framed decoded byte stream.
// ============================================================================
module x86_call_offset_untranslate import x86cou_pkg::*; #(
   parameter int FRAME_LIMIT     = 32768,
   parameter int MAX_FRAME_BYTES = 32768
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] data_byte, [23:8] frame_length
   input  logic [1:0]  req_tuser,   // [0] e8_enabled, [1] stream_restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // translation_size
);

`include "x86_call_offset_untranslate_defines.svh"

   // Input register
   logic        in_valid_ff, in_valid_in;
   logic [23:0] in_data_ff;
   logic [1:0]  in_user_ff;

   // Block state
   logic [31:0] size_ff;
   logic [31:0] pos_ff, pos_in;
   logic [15:0] frames_ff, frames_in;
   logic [15:0] offset_ff, offset_in;
   logic [2:0]  hc_ff, hc_in;
   logic [31:0] call_pos_ff, call_pos_in;
   logic [7:0]  held_ff [4];

   // Processing terms
   logic        room, proc_fire;
   logic [7:0]  b;
   logic [16:0] len_raw, len;
   logic        e8_en, restart;
   logic [31:0] pos_eff;
   logic [15:0] frames_eff, offset_eff;
   logic [2:0]  hc_eff;
   logic        last, translated, complete, start_hold, emit_b, flush;
   logic [31:0] raw, r;
   logic [33:0] v_plus_cp;
   logic        in_range;
   push_type    push;

   assign csr_ready  = 1'b1;
   assign proc_fire  = in_valid_ff && room;
   assign req_tready = !in_valid_ff || proc_fire;

   // Hold the accepted beat until the queue can take its group
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_user_ff <= req_tuser;
      end
   end

   // Size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         size_ff <= csr_data;
      end
   end

   // Decode beat, clamp length, apply restart
   always_comb begin
      b       = in_data_ff[7:0];
      len_raw = {1'b0, in_data_ff[23:8]};
      e8_en   = in_user_ff[0];
      restart = in_user_ff[1];
      len     = (len_raw == '0) ? 17'd1 : len_raw;
      if (len > 17'(MAX_FRAME_BYTES)) begin
         len = 17'(MAX_FRAME_BYTES);
      end
      pos_eff    = restart ? '0 : pos_ff;
      frames_eff = restart ? '0 : frames_ff;
      offset_eff = restart ? '0 : offset_ff;
      hc_eff     = restart ? '0 : hc_ff;

      last       = ({1'b0, offset_eff} + 17'd1) >= len;
      translated = (size_ff != '0) && (17'(frames_eff) < 17'(FRAME_LIMIT))
                   && (len > 17'(MIN_XLAT_LEN)) && e8_en;
      complete   = (hc_eff == 3'(CALL_BYTES - 1));
      start_hold = (hc_eff == '0) && translated && (b == E8_OPCODE)
                   && (({1'b0, offset_eff} + 17'(HOLD_MARGIN)) < len);
      emit_b     = ((hc_eff != '0) && (complete || last))
                   || ((hc_eff == '0) && !start_hold);
      flush      = (hc_ff != '0) && (restart || complete || last);
   end

   // Operand range check and rewrite
   always_comb begin
      raw       = {b, held_ff[3], held_ff[2], held_ff[1]};
      v_plus_cp = {{2{raw[31]}}, raw} + {{2{call_pos_ff[31]}}, call_pos_ff};
      in_range  = !v_plus_cp[33] && ($signed(raw) < $signed(size_ff));
      r         = raw[31] ? (raw + size_ff) : (raw - call_pos_ff);
   end

   // Build the beat group for the queue
   always_comb begin
      for (int j = 0; j < CALL_BYTES - 1; j++) begin
         push.beats[j].data = (3'(j) < hc_ff) ? held_ff[j] : b;
         push.beats[j].last = (3'(j) == hc_ff) && last;
      end
      push.beats[CALL_BYTES-1].data = b;
      push.beats[CALL_BYTES-1].last = last;
      if (complete && in_range) begin
         push.beats[1].data = r[7:0];
         push.beats[2].data = r[15:8];
         push.beats[3].data = r[23:16];
         push.beats[4].data = r[31:24];
      end
      push.cnt = '0;
      if (proc_fire) begin
         push.cnt = (flush ? hc_ff : 3'd0) + {2'd0, emit_b};
      end
   end

   // Next state of position, frame count, offset and hold
   always_comb begin
      pos_in      = pos_eff;
      frames_in   = frames_eff;
      offset_in   = offset_eff + 16'd1;
      call_pos_in = call_pos_ff;
      if (last) begin
         offset_in = '0;
         if (17'(frames_eff) < 17'(FRAME_LIMIT)) begin
            frames_in = frames_eff + 16'd1;
            if (size_ff != '0) begin
               pos_in = pos_eff + 32'(len);
            end
         end
      end
      hc_in = '0;
      if (start_hold) begin
         hc_in       = 3'd1;
         call_pos_in = pos_eff + 32'(offset_eff);
      end else if ((hc_eff != '0) && !complete && !last) begin
         hc_in = hc_eff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         frames_ff   <= '0;
         offset_ff   <= '0;
         hc_ff       <= '0;
         call_pos_ff <= '0;
      end else if (proc_fire) begin
         pos_ff      <= pos_in;
         frames_ff   <= frames_in;
         offset_ff   <= offset_in;
         hc_ff       <= hc_in;
         call_pos_ff <= call_pos_in;
      end
   end

   // Store held call bytes
   always_ff @(posedge clock) begin
      if (proc_fire) begin
         if (start_hold) begin
            held_ff[0] <= b;
         end else if ((hc_eff != '0) && !complete) begin
            held_ff[hc_eff[1:0]] <= b;
         end
      end
   end

   x86cou_beat_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A hold always starts with the opcode byte
   `X86COU_ASSERT_IMPLY(a_hold_opcode, hc_ff != 3'd0, held_ff[0] == E8_OPCODE, "hold without E8 opcode")
   // A finished call leaves output to deliver
   `X86COU_ASSERT_NEXT(a_call_out, proc_fire && complete, rsp_tvalid, "finished call not queued")
   // An operand byte that neither ends the call nor the frame grows the hold
   `X86COU_ASSERT_NEXT(a_hold_grow, proc_fire && (hc_eff != 3'd0) && !complete && !last, hc_ff == $past(hc_ff) + 3'd1, "hold count did not advance")

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Streams framed bytes with embedded E8 calls through the CALL offset
// untranslate block and checks every output beat against a cycle-free
// model of the untranslation, across several translation size settings.
// ============================================================================
module testbench;
   import x86cou_pkg::*;

   localparam int FRAME_LIMIT     = 32768;
   localparam int MAX_FRAME_BYTES = 32768;
   localparam int SETTLE_CYCLES   = 8;
   localparam int LONG_HOLD       = 200;
   localparam int PHASE_BYTES     = 35;

   // One input byte with its side information
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] frame_length;
      logic        e8_enabled;
      logic        stream_restart;
   } stream_byte_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [7:0] data_byte, [23:8] frame_length
   logic [1:0]  req_tuser  = '0;   // [0] e8_enabled, [1] stream_restart
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] out_byte
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data   = '0;

   // Stimulus and expectation stores
   stream_byte_t byte_queue [$];
   out_beat_type expected_beats [$];
   stream_byte_t cur_byte;
   int unsigned  pushed_bytes = 0;
   int unsigned  fail_count   = 0;
   int unsigned  send_gap     = 0;
   int unsigned  stall_left   = 0;
   logic         calm            = 1'b0;
   logic         long_hold_armed = 1'b0;
   logic         long_hold_done  = 1'b0;

   // Untranslation state mirrored from the block
   logic [31:0] xlat_size    = '0;
   logic [31:0] stream_pos   = '0;
   int unsigned frame_count  = 0;
   int unsigned frame_offset = 0;
   logic [7:0]  call_bytes [CALL_BYTES];
   int unsigned call_fill    = 0;
   logic [31:0] call_pos     = '0;

   x86_call_offset_untranslate #(
      .FRAME_LIMIT    (FRAME_LIMIT),
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // Advance the untranslation model by one accepted byte, queue its output beats
   task automatic untranslate_byte(input stream_byte_t item);
      int unsigned len;
      int unsigned k;
      logic        closes;
      logic        scan;
      logic [31:0] operand;
      logic [31:0] fixed;
      longint      value;
      len = item.frame_length;
      if (len == 0) len = 1;
      if (len > MAX_FRAME_BYTES) len = MAX_FRAME_BYTES;
      // new stream: release a pending call untouched, then clear position, frame count and offset
      if (item.stream_restart) begin
         for (k = 0; k < call_fill; k++)
            expected_beats.push_back(out_beat_type'{data: call_bytes[k], last: 1'b0});
         call_fill    = 0;
         stream_pos   = '0;
         frame_count  = 0;
         frame_offset = 0;
      end
      closes = (frame_offset + 1 >= len);
      scan   = (xlat_size != 0) && (frame_count < FRAME_LIMIT) &&
               (len > MIN_XLAT_LEN) && item.e8_enabled;
      if (call_fill > 0) begin
         call_bytes[call_fill] = item.data_byte;
         call_fill++;
         if (call_fill == CALL_BYTES) begin
            // rewrite the operand when it lies in [-call position, size)
            operand = {call_bytes[4], call_bytes[3], call_bytes[2], call_bytes[1]};
            value   = longint'($signed(operand));
            if (value >= -longint'($signed(call_pos)) &&
                value < longint'($signed(xlat_size))) begin
               fixed = (value >= 0) ? operand - call_pos : operand + xlat_size;
               {call_bytes[4], call_bytes[3], call_bytes[2], call_bytes[1]} = fixed;
            end
            for (k = 0; k < CALL_BYTES; k++)
               expected_beats.push_back(out_beat_type'{data: call_bytes[k],
                                                       last: closes && k == CALL_BYTES - 1});
            call_fill = 0;
         end else if (closes) begin
            // frame ended inside a call: emit what was held as is
            for (k = 0; k < call_fill; k++)
               expected_beats.push_back(out_beat_type'{data: call_bytes[k],
                                                       last: k + 1 == call_fill});
            call_fill = 0;
         end
      end else if (scan && item.data_byte == E8_OPCODE &&
                   frame_offset + HOLD_MARGIN < len) begin
         call_bytes[0] = item.data_byte;
         call_fill     = 1;
         call_pos      = stream_pos + frame_offset;
      end else begin
         expected_beats.push_back(out_beat_type'{data: item.data_byte, last: closes});
      end
      if (closes) begin
         if (frame_count < FRAME_LIMIT) begin
            if (xlat_size != 0) stream_pos += len;
            frame_count++;
         end
         frame_offset = 0;
      end else begin
         frame_offset = (frame_offset + 1) & 32'hFFFF;
      end
   endtask

   // Driver: feed queued bytes, hold while stalled, idle in random bursts
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready) untranslate_byte(cur_byte);
         if (req_tvalid && !req_tready) begin
            // hold the current beat
         end else if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (byte_queue.size() > 0 && !calm && $urandom_range(0, 11) == 0) begin
            send_gap   <= $urandom_range(0, 8);
            req_tvalid <= 1'b0;
         end else if (byte_queue.size() > 0) begin
            cur_byte    = byte_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {cur_byte.frame_length, cur_byte.data_byte};
            req_tuser  <= {cur_byte.stream_restart, cur_byte.e8_enabled};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: compare each beat with the oldest expectation, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected beat: out_byte %02h frame_end %0b", rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               if (rsp_tdata !== expected_beats[0].data) begin
                  $error("out_byte mismatch: expected %02h, actual %02h",
                         expected_beats[0].data, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== expected_beats[0].last) begin
                  $error("frame_end mismatch: expected %0b, actual %0b",
                         expected_beats[0].last, rsp_tlast);
                  fail_count++;
               end
               void'(expected_beats.pop_front());
            end
         end
         if (long_hold_armed && !long_hold_done) begin
            long_hold_done <= 1'b1;
            stall_left     <= LONG_HOLD;
            rsp_tready     <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic [15:0] len,
                            input logic e8, input logic rst);
      byte_queue.push_back(stream_byte_t'{b, len, e8, rst});
      pushed_bytes++;
   endtask

   // E8 opcode followed by a little-endian operand
   task automatic push_call(input logic [31:0] operand, input logic [15:0] len,
                            input logic e8, input logic rst);
      push_byte(E8_OPCODE, len, e8, rst);
      push_byte(operand[7:0], len, e8, 1'b0);
      push_byte(operand[15:8], len, e8, 1'b0);
      push_byte(operand[23:16], len, e8, 1'b0);
      push_byte(operand[31:24], len, e8, 1'b0);
   endtask

   task automatic push_filler(input int unsigned n, input logic [15:0] len, input logic e8);
      repeat (n) push_byte(8'($urandom), len, e8, 1'b0);
   endtask

   // Operands around both edges of the rewrite window and fully random
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 4))
         0:       return 32'($urandom_range(0, 4000));
         1:       return -32'($urandom_range(1, 4000));
         2:       return xlat_size - 32'($urandom_range(0, 1));
         3:       return 32'($urandom_range(0, 3)) - 32'(stream_pos);
         default: return $urandom;
      endcase
   endfunction

   // Well-formed frame of constant length, rich in calls
   task automatic push_frame(input int unsigned len, input logic e8, input logic rst);
      int unsigned pos;
      logic [7:0]  b;
      pos = 0;
      while (pos < len) begin
         if (pos + HOLD_MARGIN < len && $urandom_range(0, 4) == 0) begin
            push_call(pick_operand(), len[15:0], e8, rst && pos == 0);
            pos += CALL_BYTES;
         end else begin
            b = ($urandom_range(0, 9) == 0) ? E8_OPCODE : 8'($urandom);
            push_byte(b, len[15:0], e8, rst && pos == 0);
            pos++;
         end
      end
   endtask

   // Broken sequences: length, flag and restart change from byte to byte
   task automatic push_noise(input int unsigned n);
      logic [15:0] len;
      logic [7:0]  b;
      repeat (n) begin
         len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
         b   = ($urandom_range(0, 3) == 0) ? E8_OPCODE : 8'($urandom);
         push_byte(b, len, 1'($urandom), $urandom_range(0, 15) == 0);
      end
   endtask

   task automatic push_traffic(input int unsigned target);
      int unsigned start;
      int unsigned len;
      start = pushed_bytes;
      push_frame($urandom_range(11, 30), 1'b1, 1'b1);
      while (pushed_bytes - start < target) begin
         if ($urandom_range(0, 7) == 0) begin
            push_noise($urandom_range(3, 8));
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : $urandom_range(11, 40);
            push_frame(len, $urandom_range(0, 9) != 0, $urandom_range(0, 19) == 0);
         end
      end
   endtask

   task automatic write_size(input logic [31:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      xlat_size  = value;
      csr_valid <= 1'b0;
   endtask

   // Wait for all bytes and beats; close the frame if a call is still held
   task automatic drain_block();
      forever begin
         @(negedge clock);
         if (byte_queue.size() == 0 && !req_tvalid && expected_beats.size() == 0) begin
            if (call_fill == 0) break;
            push_byte(8'($urandom), 16'd1, 1'b0, 1'b0);
         end
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [31:0] sizes [7];
      int          p;
      sizes = '{32'd12000000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
                32'd1000, 32'hFFFF_FFFF, $urandom};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // size still at reset value: calls pass through
      push_call(32'd5, 16'd12, 1'b1, 1'b1);
      push_filler(7, 16'd12, 1'b1);
      drain_block();

      write_size(32'd12000000);
      // positive and negative in-range operands, then E8 too close to frame end
      push_call(32'd5, 16'd16, 1'b1, 1'b1);
      push_call(-32'd5, 16'd16, 1'b1, 1'b0);
      push_byte(E8_OPCODE, 16'd16, 1'b1, 1'b0);
      push_filler(5, 16'd16, 1'b1);
      // operand above the window, then E8 flag clear
      push_call(32'h7FFF_FFFF, 16'd12, 1'b1, 1'b0);
      push_filler(7, 16'd12, 1'b1);
      push_call(32'd5, 16'd11, 1'b0, 1'b0);
      push_filler(6, 16'd11, 1'b0);
      // frame shortened while a call is held
      push_byte(E8_OPCODE, 16'd12, 1'b1, 1'b0);
      push_filler(2, 16'd12, 1'b1);
      push_byte(8'h5A, 16'd4, 1'b1, 1'b0);
      // restart while a call is held, then extreme lengths
      push_byte(E8_OPCODE, 16'd12, 1'b1, 1'b0);
      push_byte(8'h00, 16'd12, 1'b1, 1'b0);
      push_byte(8'hFF, 16'd12, 1'b1, 1'b1);
      push_byte(8'hE8, 16'hFFFF, 1'b1, 1'b0);
      push_byte(8'h01, 16'd0, 1'b1, 1'b0);
      drain_block();

      // random traffic across several size settings
      for (p = 0; p < 7; p++) begin
         write_size(sizes[p]);
         push_traffic(PHASE_BYTES);
         if (p == 1) long_hold_armed <= 1'b1;
         drain_block();
      end

      // final stretch without idling on either side
      calm <= 1'b1;
      write_size(32'd12000000);
      push_traffic(40);
      drain_block();

      if (fail_count == 0) begin
         $display("PASS x86_call_offset_untranslate");
      end else begin
         $display("FAIL x86_call_offset_untranslate");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL x86_call_offset_untranslate");
      $finish;
   end

endmodule
